>>> rtl/polygon_hit_test_defines.svh
// assertion macros for the polygon hit test block
`ifndef POLYGON_HIT_TEST_DEFINES_SVH
`define POLYGON_HIT_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define PHT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PHT_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define PHT_ASSERT_IMP(label, clk, rst_n, a, c)
`define PHT_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/pht_pkg.sv
package pht_pkg;
    localparam int MAX_POLYGONS = 512;
    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 12;
    localparam int PB = $clog2(MAX_POLYGONS);
    localparam int VB = $clog2(MAX_VERTICES);
    localparam int CB = VB + 1;
    localparam int NB = PB + 1;
    localparam int AB = PB + VB;
    localparam int DW = COORD_BITS + 1;
    localparam int NW = 2 * COORD_BITS + 2;
    localparam int QW = NW - COORD_BITS;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ADD    = 2'd0;
    localparam t_cmd CMD_CLEAR  = 2'd1;
    localparam t_cmd CMD_QUERY  = 2'd2;
    localparam t_cmd CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  start_new;
    } t_in;

    typedef struct packed {
        logic       hit;
        logic [8:0] polygon_index;
        logic       rejected;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_POLY_RD, ST_POLY_WAIT, ST_V0,
        ST_EDGE_RD, ST_EDGE, ST_DIV, ST_POLY_END, ST_DONE
    } t_state;
endpackage

>>> rtl/polygon_hit_test.sv
// channel | ports                  | qualifier
// command | i_item (t_in)          | i_start high while o_busy low
// result  | o_result (t_out)       | o_valid, one cycle, cannot stall
// an add passes through ST_ADD_RD and ST_ADD_WR, a clear or an unused command
// through ST_DONE; o_valid rises in the same cycle that o_busy falls
// a query takes ST_POLY_RD and ST_POLY_WAIT per polygon, ST_EDGE_RD and ST_EDGE
// per vertex, ST_V0 for the closing edge, ST_DIV per edge that needs the quotient
// and ST_POLY_END; the divider is restoring and the vertex memory is single-port
// reset clears the state, o_valid and the polygon count; there is no clearing pass
`include "polygon_hit_test_defines.svh"
module polygon_hit_test (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pht_pkg::t_in  i_item,
    output logic          o_busy,
    output logic          o_valid,
    output pht_pkg::t_out o_result
);
    logic [2*pht_pkg::COORD_BITS-1:0] r_vmem [0:(1 << pht_pkg::AB)-1];
    logic [pht_pkg::CB-1:0]           r_cmem [0:(1 << pht_pkg::PB)-1];
    logic [2*pht_pkg::COORD_BITS-1:0] r_vq;
    logic [pht_pkg::CB-1:0]           r_cq;

    pht_pkg::t_state r_st, n_st;
    pht_pkg::t_in    r_it;
    logic [pht_pkg::NB-1:0] r_pc;
    logic [pht_pkg::NB-1:0] r_pi;
    logic [pht_pkg::CB-1:0] r_n, r_k;
    logic [pht_pkg::COORD_BITS-1:0] r_ax, r_ay, r_x0, r_y0, r_dax;
    logic r_par;
    logic r_valid;
    pht_pkg::t_out r_res;
    logic [pht_pkg::NW-1:0] r_num;
    logic [pht_pkg::DW-1:0] r_den;
    logic [pht_pkg::NW-1:0] r_rem, r_quo;
    logic [5:0] r_dc;
    logic r_neg;

    logic v_we;
    logic [pht_pkg::AB-1:0] v_addr;
    logic c_we;
    logic [pht_pkg::PB-1:0] c_addr;
    logic [pht_pkg::CB-1:0] c_wd;

    logic [pht_pkg::COORD_BITS-1:0] bx, by, px, py;
    logic right, between;
    logic [pht_pkg::NB-1:0] last_p;
    logic [pht_pkg::CB-1:0] k1;
    logic signed [pht_pkg::DW:0] dy, dx, dpy;
    logic signed [2*pht_pkg::DW+1:0] prod;
    logic [pht_pkg::NW-1:0] trial;
    logic signed [pht_pkg::NW+1:0] xi;
    logic add_ok;

    assign px = r_it.x;
    assign py = r_it.y;
    assign bx = (r_st == pht_pkg::ST_V0) ? r_x0 : r_vq[pht_pkg::COORD_BITS-1:0];
    assign by = (r_st == pht_pkg::ST_V0) ? r_y0
        : r_vq[2*pht_pkg::COORD_BITS-1:pht_pkg::COORD_BITS];
    assign right = (r_ax > px) || (bx > px);
    assign between = ((r_ay > py) && (by < py)) || ((r_ay < py) && (by > py));
    assign last_p = r_pc - 1'b1;
    assign k1 = r_k + 1'b1;
    assign dy = $signed({2'b0, by}) - $signed({2'b0, r_ay});
    assign dx = $signed({2'b0, bx}) - $signed({2'b0, r_ax});
    assign dpy = $signed({2'b0, py}) - $signed({2'b0, r_ay});
    assign prod = dpy * dx;
    assign trial = {r_rem[pht_pkg::NW-2:0], r_num[pht_pkg::NW-1]};
    assign xi = $signed({2'b0, {pht_pkg::QW{1'b0}}, r_dax})
        + (r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo}));
    assign add_ok = r_it.start_new ? (r_pc < pht_pkg::NB'(pht_pkg::MAX_POLYGONS))
        : ((r_pc != '0) && (r_cq < pht_pkg::CB'(pht_pkg::MAX_VERTICES)));

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            pht_pkg::ST_IDLE: begin
                if (i_start) begin
                    priority case (i_item.cmd)
                        pht_pkg::CMD_ADD:   n_st = pht_pkg::ST_ADD_RD;
                        pht_pkg::CMD_QUERY: n_st = pht_pkg::ST_POLY_RD;
                        default:            n_st = pht_pkg::ST_DONE;
                    endcase
                end
            end
            pht_pkg::ST_ADD_RD:    n_st = pht_pkg::ST_ADD_WR;
            pht_pkg::ST_ADD_WR:    n_st = pht_pkg::ST_IDLE;
            pht_pkg::ST_POLY_RD:
                n_st = (r_pi >= r_pc) ? pht_pkg::ST_DONE : pht_pkg::ST_POLY_WAIT;
            pht_pkg::ST_POLY_WAIT: n_st = pht_pkg::ST_EDGE_RD;
            pht_pkg::ST_EDGE_RD: begin
                if (r_k == '0) n_st = (r_n == '0) ? pht_pkg::ST_POLY_END : pht_pkg::ST_EDGE;
                else n_st = pht_pkg::ST_EDGE;
            end
            pht_pkg::ST_EDGE, pht_pkg::ST_V0: begin
                if (r_k == '0)
                    n_st = (r_n == pht_pkg::CB'(1)) ? pht_pkg::ST_V0 : pht_pkg::ST_EDGE_RD;
                else if (right && between) n_st = pht_pkg::ST_DIV;
                else if (r_st == pht_pkg::ST_V0) n_st = pht_pkg::ST_POLY_END;
                else n_st = (k1 == r_n) ? pht_pkg::ST_V0 : pht_pkg::ST_EDGE_RD;
            end
            pht_pkg::ST_DIV: begin
                if (r_dc == 6'd0)
                    n_st = (r_k > r_n) ? pht_pkg::ST_POLY_END
                         : ((r_k == r_n) ? pht_pkg::ST_V0 : pht_pkg::ST_EDGE_RD);
            end
            pht_pkg::ST_POLY_END: n_st = r_par ? pht_pkg::ST_DONE : pht_pkg::ST_POLY_RD;
            pht_pkg::ST_DONE:      n_st = pht_pkg::ST_IDLE;
            default:               n_st = pht_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        v_we = 1'b0;
        c_we = 1'b0;
        c_addr = r_pi[pht_pkg::PB-1:0];
        c_wd = r_cq + 1'b1;
        v_addr = {r_pi[pht_pkg::PB-1:0], r_k[pht_pkg::VB-1:0]};
        unique case (r_st)
            pht_pkg::ST_ADD_RD: c_addr = last_p[pht_pkg::PB-1:0];
            pht_pkg::ST_ADD_WR: begin
                v_we = add_ok;
                c_we = add_ok;
                if (r_it.start_new) begin
                    c_addr = r_pc[pht_pkg::PB-1:0];
                    c_wd = pht_pkg::CB'(1);
                    v_addr = {r_pc[pht_pkg::PB-1:0], {pht_pkg::VB{1'b0}}};
                end else begin
                    c_addr = last_p[pht_pkg::PB-1:0];
                    v_addr = {last_p[pht_pkg::PB-1:0], r_cq[pht_pkg::VB-1:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_vmem[v_addr] <= {r_it.y, r_it.x};
        r_vq <= r_vmem[v_addr];
        if (c_we) r_cmem[c_addr] <= c_wd;
        r_cq <= r_cmem[c_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pht_pkg::ST_IDLE;
            r_pc <= '0;
            r_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_valid <= 1'b0;
            if (r_st == pht_pkg::ST_IDLE && i_start && i_item.cmd == pht_pkg::CMD_CLEAR)
                r_pc <= '0;
            if (r_st == pht_pkg::ST_ADD_WR) begin
                r_valid <= 1'b1;
                if (add_ok && r_it.start_new) r_pc <= r_pc + 1'b1;
            end
            if (r_st == pht_pkg::ST_DONE) r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            pht_pkg::ST_IDLE: begin
                r_it <= i_item;
                r_pi <= '0;
                r_res <= '0;
            end
            pht_pkg::ST_ADD_WR: r_res <= '{hit: 1'b0, polygon_index: 9'd0, rejected: !add_ok};
            pht_pkg::ST_POLY_RD: begin
                r_k <= '0;
                r_par <= 1'b0;
            end
            pht_pkg::ST_POLY_WAIT: begin
                r_n <= (r_cq > pht_pkg::CB'(pht_pkg::MAX_VERTICES))
                    ? pht_pkg::CB'(pht_pkg::MAX_VERTICES) : r_cq;
            end
            pht_pkg::ST_EDGE, pht_pkg::ST_V0: begin
                if (r_k == '0 && r_st == pht_pkg::ST_EDGE) begin
                    r_x0 <= bx;
                    r_y0 <= by;
                end
                r_ax <= bx;
                r_ay <= by;
                if (r_k != '0 && right && between) begin
                    r_dax <= r_ax;
                    r_neg <= prod[2*pht_pkg::DW+1] ^ dy[pht_pkg::DW];
                    r_num <= pht_pkg::NW'(prod[2*pht_pkg::DW+1] ? -prod : prod);
                    r_den <= pht_pkg::DW'(dy[pht_pkg::DW] ? -dy : dy);
                    r_rem <= '0;
                    r_quo <= '0;
                    r_dc <= 6'(pht_pkg::NW);
                end
                if (r_st == pht_pkg::ST_EDGE || r_k != '0) r_k <= k1;
            end
            pht_pkg::ST_DIV: begin
                if (r_dc != 6'd0) begin
                    r_dc <= r_dc - 1'b1;
                    r_num <= {r_num[pht_pkg::NW-2:0], 1'b0};
                    if (trial >= pht_pkg::NW'(r_den)) begin
                        r_rem <= trial - pht_pkg::NW'(r_den);
                        r_quo <= {r_quo[pht_pkg::NW-2:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_quo <= {r_quo[pht_pkg::NW-2:0], 1'b0};
                    end
                end else begin
                    if (xi > $signed({2'b0, {pht_pkg::QW{1'b0}}, px}) || px == r_dax)
                        r_par <= !r_par;
                end
            end
            pht_pkg::ST_POLY_END: begin
                if (r_par) r_res <= '{hit: 1'b1, polygon_index: 9'(r_pi), rejected: 1'b0};
                r_pi <= r_pi + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_st != pht_pkg::ST_IDLE);
    assign o_valid = r_valid;
    assign o_result = r_res;

    `PHT_ASSERT_NXT(a_busy_after_start, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `PHT_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, r_st == pht_pkg::ST_IDLE)
    `PHT_ASSERT_IMP(a_pc_range, i_clk, i_rst_n, 1'b1, r_pc <= pht_pkg::NB'(pht_pkg::MAX_POLYGONS))
    `PHT_ASSERT_IMP(a_no_conflict, i_clk, i_rst_n, o_valid, !(o_result.hit && o_result.rejected))
endmodule

>>> verif/testbench.sv
module testbench;
    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    pht_pkg::t_in   item = '0;
    logic           busy;
    logic           valid;
    pht_pkg::t_out  result;

    polygon_hit_test dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_item(item),
        .o_busy(busy), .o_valid(valid), .o_result(result)
    );

    always #6 clk = ~clk;

    // shadow of the polygon table
    logic [2*pht_pkg::COORD_BITS-1:0] shadow_vtx [pht_pkg::MAX_POLYGONS*pht_pkg::MAX_VERTICES];
    int              shadow_nv [pht_pkg::MAX_POLYGONS];
    int              shadow_np;
    pht_pkg::t_out   pending_results [$];
    int              errors;
    int              n_queries;
    int              n_hits;
    int              n_rejects;

    function automatic bit point_in_poly(int p, longint px, longint py);
        int     n;
        int     k;
        int     kb;
        bit     par;
        longint ax, ay, bx, by, xi;
        n = shadow_nv[p];
        par = 1'b0;
        for (k = 0; k < n; k++) begin
            kb = (k + 1 < n) ? k + 1 : 0;
            ax = longint'(shadow_vtx[p*pht_pkg::MAX_VERTICES+k][11:0]);
            ay = longint'(shadow_vtx[p*pht_pkg::MAX_VERTICES+k][23:12]);
            bx = longint'(shadow_vtx[p*pht_pkg::MAX_VERTICES+kb][11:0]);
            by = longint'(shadow_vtx[p*pht_pkg::MAX_VERTICES+kb][23:12]);
            if ((ax > px || bx > px) && ((ay > py && by < py) || (ay < py && by > py))) begin
                xi = ax + ((py - ay) * (bx - ax)) / (by - ay);
                if (xi > px || px == ax) par = ~par;
            end
        end
        return par;
    endfunction

    function automatic pht_pkg::t_out hit_test_predict(pht_pkg::t_in it);
        pht_pkg::t_out r;
        bit            ok;
        r = '0;
        if (it.cmd == pht_pkg::CMD_ADD) begin
            ok = 1'b1;
            if (it.start_new) begin
                if (shadow_np >= pht_pkg::MAX_POLYGONS) ok = 1'b0;
                else begin
                    shadow_nv[shadow_np] = 0;
                    shadow_np++;
                end
            end else if (shadow_np == 0 || shadow_nv[shadow_np-1] >= pht_pkg::MAX_VERTICES) begin
                ok = 1'b0;
            end
            if (ok) begin
                shadow_vtx[(shadow_np-1)*pht_pkg::MAX_VERTICES + shadow_nv[shadow_np-1]] =
                    {it.y, it.x};
                shadow_nv[shadow_np-1]++;
            end else begin
                r.rejected = 1'b1;
            end
        end else if (it.cmd == pht_pkg::CMD_CLEAR) begin
            shadow_np = 0;
        end else if (it.cmd == pht_pkg::CMD_QUERY) begin
            for (int i = 0; i < shadow_np; i++) begin
                if (point_in_poly(i, longint'(it.x), longint'(it.y))) begin
                    r.hit = 1'b1;
                    r.polygon_index = i[8:0];
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic send_cmd(pht_pkg::t_in it, bit has_exp = 1'b0,
                            pht_pkg::t_out exp_r = '0);
        pht_pkg::t_out p;
        int            gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge clk);
        p = hit_test_predict(it);
        if (has_exp && p != exp_r) begin
            $error("table row disagrees: expected %p predicted %p", exp_r, p);
            errors++;
        end
        if (it.cmd == pht_pkg::CMD_QUERY) begin
            n_queries++;
            if (p.hit) n_hits++;
        end
        if (p.rejected) n_rejects++;
        pending_results.push_back(has_exp ? exp_r : p);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk) begin
        pht_pkg::t_out e;
        if (rst_n && valid) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %p", result);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (result.hit !== e.hit) begin
                    $error("hit expected %0d actual %0d", e.hit, result.hit);
                    errors++;
                end
                if (result.polygon_index !== e.polygon_index) begin
                    $error("polygon_index expected %0d actual %0d",
                           e.polygon_index, result.polygon_index);
                    errors++;
                end
                if (result.rejected !== e.rejected) begin
                    $error("rejected expected %0d actual %0d", e.rejected, result.rejected);
                    errors++;
                end
            end
        end
    end

    function automatic pht_pkg::t_in mk(pht_pkg::t_cmd c, int x, int y, bit sn);
        pht_pkg::t_in it;
        it.cmd = c;
        it.x = x[11:0];
        it.y = y[11:0];
        it.start_new = sn;
        return it;
    endfunction

    typedef struct {
        pht_pkg::t_in  it;
        bit            has_exp;
        pht_pkg::t_out exp_r;
    } t_row;

    t_row stim_table [$];

    task automatic add_poly(int cx, int cy, int r, int nv);
        real          a;
        pht_pkg::t_in it;
        for (int k = 0; k < nv; k++) begin
            a = 6.2831853 * k / nv + ($urandom_range(0, 99) / 300.0);
            it = mk(pht_pkg::CMD_ADD, cx + $rtoi(r * $cos(a)), cy + $rtoi(r * $sin(a)),
                    k == 0);
            send_cmd(it);
        end
    endtask

    initial begin
        #2000000000;
        $display("[polygon_hit_test] ERROR");
        $finish;
    end

    initial begin
        pht_pkg::t_in it;
        int           ncx, ncy;
        errors = 0;
        n_queries = 0;
        n_hits = 0;
        n_rejects = 0;
        shadow_np = 0;
        foreach (shadow_nv[i]) shadow_nv[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        stim_table.push_back('{mk(pht_pkg::CMD_QUERY, 100, 100, 1'b0), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_ADD, 5, 5, 1'b0), 1'b1,
                               pht_pkg::t_out'{1'b0, 9'd0, 1'b1}});
        stim_table.push_back('{mk(pht_pkg::CMD_UNUSED, 4095, 4095, 1'b1), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_ADD, 0, 0, 1'b1), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_ADD, 4095, 0, 1'b0), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_ADD, 4095, 4095, 1'b0), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_ADD, 0, 4095, 1'b0), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_QUERY, 2000, 2000, 1'b0), 1'b0, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_QUERY, 0, 2000, 1'b0), 1'b0, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_QUERY, 4095, 4095, 1'b0), 1'b0, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_QUERY, 0, 0, 1'b0), 1'b0, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_ADD, 10, 10, 1'b1), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_QUERY, 10, 10, 1'b0), 1'b0, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_ADD, 50, 50, 1'b0), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_QUERY, 30, 30, 1'b0), 1'b0, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_ADD, 2730, 1365, 1'b1), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_ADD, 1365, 2730, 1'b0), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_ADD, 3000, 3000, 1'b0), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_QUERY, 2400, 2400, 1'b0), 1'b0, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_CLEAR, 4095, 4095, 1'b1), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_QUERY, 2000, 2000, 1'b0), 1'b1, '0});
        stim_table.push_back('{mk(pht_pkg::CMD_ADD, 1, 1, 1'b0), 1'b1,
                               pht_pkg::t_out'{1'b0, 9'd0, 1'b1}});
        foreach (stim_table[i])
            send_cmd(stim_table[i].it, stim_table[i].has_exp, stim_table[i].exp_r);

        // polygon full
        send_cmd(mk(pht_pkg::CMD_ADD, 7, 7, 1'b1));
        for (int k = 0; k < pht_pkg::MAX_VERTICES; k++)
            send_cmd(mk(pht_pkg::CMD_ADD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                        1'b0));
        for (int q = 0; q < 4; q++)
            send_cmd(mk(pht_pkg::CMD_QUERY, $urandom_range(0, 4095), $urandom_range(0, 4095),
                        1'b0));

        // hold off until drained
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);

        // table full: one-vertex polygons, queried rarely
        send_cmd(mk(pht_pkg::CMD_CLEAR, 0, 0, 1'b0));
        for (int p = 0; p < pht_pkg::MAX_POLYGONS; p++) begin
            send_cmd(mk(pht_pkg::CMD_ADD, (p * 8) % 4096, 100, 1'b1));
            if (p % 128 == 0) send_cmd(mk(pht_pkg::CMD_QUERY, 4095, 4095, 1'b0));
        end
        send_cmd(mk(pht_pkg::CMD_ADD, 1, 1, 1'b1));
        send_cmd(mk(pht_pkg::CMD_ADD, 2, 2, 1'b0));
        send_cmd(mk(pht_pkg::CMD_QUERY, 8, 100, 1'b0));
        send_cmd(mk(pht_pkg::CMD_CLEAR, 0, 0, 1'b0));

        // random phase: mostly well-formed polygons, queries near them
        for (int r = 0; r < 40; r++) begin
            case ($urandom_range(0, 19))
                0: send_cmd(mk(pht_pkg::CMD_CLEAR, $urandom, $urandom, $urandom_range(0, 1)));
                1: send_cmd(mk(pht_pkg::CMD_UNUSED, $urandom, $urandom, $urandom_range(0, 1)));
                2, 3: send_cmd(mk(pht_pkg::CMD_ADD, $urandom, $urandom, $urandom_range(0, 1)));
                4, 5, 6: begin
                    ncx = $urandom_range(200, 3900);
                    ncy = $urandom_range(200, 3900);
                    add_poly(ncx, ncy, $urandom_range(20, 190), $urandom_range(3, 10));
                end
                default: begin
                    if ($urandom_range(0, 2) == 0)
                        it = mk(pht_pkg::CMD_QUERY, $urandom, $urandom, $urandom_range(0, 1));
                    else if (shadow_np > 0 && shadow_nv[shadow_np-1] > 0)
                        it = mk(pht_pkg::CMD_QUERY,
                                shadow_vtx[(shadow_np-1)*pht_pkg::MAX_VERTICES][11:0]
                                    + $urandom_range(0, 60) - 30,
                                shadow_vtx[(shadow_np-1)*pht_pkg::MAX_VERTICES][23:12]
                                    + $urandom_range(0, 60) - 30, 1'b1);
                    else
                        it = mk(pht_pkg::CMD_QUERY, $urandom, $urandom, 1'b0);
                    send_cmd(it);
                end
            endcase
            if (shadow_np > 60) send_cmd(mk(pht_pkg::CMD_CLEAR, 0, 0, 1'b0));
        end

        fork
            wait (pending_results.size() == 0);
            repeat (5000000) @(posedge clk);
        join_any
        disable fork;
        repeat (50) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("queries %0d, hits %0d, rejected adds %0d, table filled to %0d polygons",
                 n_queries, n_hits, n_rejects, pht_pkg::MAX_POLYGONS);
        if (errors == 0) $display("[polygon_hit_test] OK");
        else $display("[polygon_hit_test] ERROR");
        $finish;
    end
endmodule
